// ----- src/mst_pkg.sv -----
// ----------------------------------------------------------------------------
// mst_pkg
// shared types and constants of the multistream sequence tracker
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int MAX_SLOTS   = 16;
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W       = 5;
  localparam int SEQ_SPACE   = 65536;
  localparam int SEQ_W       = $clog2(SEQ_SPACE);
  localparam int TOT_W       = SEQ_W + 1;
  localparam int MIN_LEN     = 32;
  localparam int CNT17_W     = 17;
  localparam int CNT32_W     = 32;
  localparam int LAT_W       = 32;
  localparam int BM_WORD_W   = 64;
  localparam int BM_OFF_W    = $clog2(BM_WORD_W);
  localparam int BM_DEPTH    = MAX_SLOTS * SEQ_SPACE / BM_WORD_W;
  localparam int BM_AW       = $clog2(BM_DEPTH);
  localparam int IN_TDATA_W  = 336;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_TUSER_W = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT17_W-1:0] CNT17_MAX = '1;
  localparam logic [CNT32_W-1:0] CNT32_MAX = '1;

  typedef enum logic [2:0] {
    ST_SHORT     = 3'd0,
    ST_UNMATCHED = 3'd1,
    ST_REJECT    = 3'd2,
    ST_DUP       = 3'd3,
    ST_NEW       = 3'd4,
    ST_REORDER   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_LOOK
  } bstate_t;

  typedef struct packed {
    logic              hit;
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [SEQ_W-1:0]  seq;
    logic [TOT_W-1:0]  total;
    logic [LAT_W-1:0]  latency;
    logic [CNT_W-1:0]  in_use;
  } item_t;

endpackage

// ----- src/mst_ram.sv -----
// ----------------------------------------------------------------------------
// mst_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module mst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/mst_front.sv -----
// ----------------------------------------------------------------------------
// mst_front
// classifies requests: length check, stream lookup, admission, range checks
// ----------------------------------------------------------------------------
module mst_front import mst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  accept,
  input  logic [CNT_W-1:0]      expected,
  output item_t                 item
);

  logic [63:0]       id_tab  [MAX_SLOTS];
  logic [TOT_W-1:0]  tot_tab [MAX_SLOTS];
  logic [CNT_W-1:0]  in_use;

  logic [63:0] sid, seq, total, sent, arrived;
  logic [15:0] len;
  logic [MAX_SLOTS-1:0] hits;
  logic              found;
  logic [SLOT_W-1:0] match;
  logic              room, bad_total, admit;
  logic [TOT_W-1:0]  eff_total;
  logic [63:0]       diff;

  assign sid     = s_tdata[63:0];
  assign seq     = s_tdata[127:64];
  assign total   = s_tdata[191:128];
  assign sent    = s_tdata[255:192];
  assign arrived = s_tdata[319:256];
  assign len     = s_tdata[335:320];

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      hits[i] = (CNT_W'(i) < in_use) && (id_tab[i] == sid);
    end
    found = 1'b0;
    match = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (hits[i]) begin
        found = 1'b1;
        match = SLOT_W'(i);
      end
    end
  end

  assign room      = (in_use < expected) && (in_use < CNT_W'(MAX_SLOTS));
  assign bad_total = (total == 64'd0) || (total > 64'(SEQ_SPACE));
  assign admit     = (len >= 16'(MIN_LEN)) && !found && room && !bad_total;
  assign eff_total = found ? tot_tab[match] : total[TOT_W-1:0];
  assign diff      = arrived - sent;

  always_comb begin
    item         = '0;
    item.status  = ST_SHORT;
    item.slot    = found ? match : in_use[SLOT_W-1:0];
    item.seq     = seq[SEQ_W-1:0];
    item.total   = eff_total;
    item.in_use  = admit ? in_use + CNT_W'(1) : in_use;
    if (arrived > sent) begin
      item.latency = (diff > 64'(CNT32_MAX)) ? CNT32_MAX : diff[LAT_W-1:0];
    end
    priority if (len < 16'(MIN_LEN)) begin
      item.status = ST_SHORT;
    end else if (!found && !room) begin
      item.status = ST_UNMATCHED;
    end else if (!found && bad_total) begin
      item.status = ST_REJECT;
    end else if (total != 64'(eff_total) || seq >= 64'(eff_total)) begin
      item.status = ST_UNMATCHED;
    end else begin
      item.status = ST_NEW;
      item.hit    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (accept && admit) begin
      in_use <= in_use + CNT_W'(1);
    end
    if (accept && admit) begin
      id_tab[in_use[SLOT_W-1:0]]  <= sid;
      tot_tab[in_use[SLOT_W-1:0]] <= total[TOT_W-1:0];
    end
  end

endmodule

// ----- src/mst_queue.sv -----
// ----------------------------------------------------------------------------
// mst_queue
// short queue of classified requests between front and back
// ----------------------------------------------------------------------------
module mst_queue import mst_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- src/mst_back.sv -----
// ----------------------------------------------------------------------------
// mst_back
// seen bitmap read-modify-write, per-stream counters and result register
// ----------------------------------------------------------------------------
module mst_back import mst_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  item_t                  head,
  input  logic                   q_empty,
  output logic                   pop,
  input  logic [CNT_W-1:0]       expected,
  output logic                   clearing,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [OUT_TUSER_W-1:0] m_tuser
);

  bstate_t state, state_next;
  logic [BM_AW-1:0] clr_cnt, clr_cnt_next;

  logic [CNT17_W-1:0] recv_a [MAX_SLOTS];
  logic [CNT32_W-1:0] dup_a  [MAX_SLOTS];
  logic [CNT17_W-1:0] reo_a  [MAX_SLOTS];
  logic [SEQ_W-1:0]   last_a [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] has_a;
  logic [CNT_W-1:0]   complete, complete_next;

  logic                 ram_we, ram_re;
  logic [BM_AW-1:0]     ram_waddr, ram_raddr;
  logic [BM_WORD_W-1:0] ram_wdata, ram_rdata;

  logic               out_free, load, upd, bit_set;
  logic [CNT17_W-1:0] recv, recv_n, reo, reo_n;
  logic [CNT32_W-1:0] dup, dup_n;
  status_t            res_status;
  logic [LAT_W-1:0]   res_lat;
  logic               res_all;

  mst_ram #(.WIDTH(BM_WORD_W), .DEPTH(BM_DEPTH)) u_bitmap (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign clearing  = (state == BS_CLEAR);
  assign out_free  = !m_tvalid || m_tready;
  assign ram_raddr = {head.slot, head.seq[SEQ_W-1:BM_OFF_W]};
  assign bit_set   = ram_rdata[head.seq[BM_OFF_W-1:0]];
  assign recv      = recv_a[head.slot];
  assign dup       = dup_a[head.slot];
  assign reo       = reo_a[head.slot];

  always_comb begin
    state_next    = state;
    clr_cnt_next  = clr_cnt;
    ram_we        = 1'b0;
    ram_waddr     = clr_cnt;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    pop           = 1'b0;
    load          = 1'b0;
    upd           = 1'b0;
    recv_n        = recv;
    dup_n         = dup;
    reo_n         = reo;
    complete_next = complete;
    res_status    = head.status;
    res_lat       = '0;
    unique case (state)
      BS_CLEAR: begin
        ram_we       = 1'b1;
        clr_cnt_next = clr_cnt + BM_AW'(1);
        if (clr_cnt == '1) begin
          state_next = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (!q_empty) begin
          if (head.hit) begin
            ram_re     = 1'b1;
            state_next = BS_LOOK;
          end else if (out_free) begin
            load = 1'b1;
            pop  = 1'b1;
          end
        end
      end
      BS_LOOK: begin
        if (out_free) begin
          load       = 1'b1;
          pop        = 1'b1;
          upd        = 1'b1;
          state_next = BS_IDLE;
          if (bit_set) begin
            res_status = ST_DUP;
            if (dup != CNT32_MAX) begin
              dup_n = dup + CNT32_W'(1);
            end
          end else begin
            ram_we    = 1'b1;
            ram_waddr = ram_raddr;
            ram_wdata = ram_rdata | (BM_WORD_W'(1) << head.seq[BM_OFF_W-1:0]);
            res_lat   = head.latency;
            if (recv != CNT17_MAX) begin
              recv_n = recv + CNT17_W'(1);
              if (recv_n == head.total) begin
                complete_next = complete + CNT_W'(1);
              end
            end
            if (has_a[head.slot] && head.seq < last_a[head.slot]) begin
              res_status = ST_REORDER;
              if (reo != CNT17_MAX) begin
                reo_n = reo + CNT17_W'(1);
              end
            end else begin
              res_status = ST_NEW;
            end
          end
        end
      end
      default: begin
        state_next = BS_CLEAR;
      end
    endcase
    res_all = (head.in_use == expected) && (complete_next == head.in_use);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BS_CLEAR;
      clr_cnt  <= '0;
      complete <= '0;
      has_a    <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        recv_a[i] <= '0;
        dup_a[i]  <= '0;
        reo_a[i]  <= '0;
        last_a[i] <= '0;
      end
    end else begin
      state    <= state_next;
      clr_cnt  <= clr_cnt_next;
      complete <= complete_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (upd) begin
        recv_a[head.slot] <= recv_n;
        dup_a[head.slot]  <= dup_n;
        reo_a[head.slot]  <= reo_n;
        if (!bit_set) begin
          last_a[head.slot] <= head.seq;
          has_a[head.slot]  <= 1'b1;
        end
      end
    end
    if (load) begin
      m_tuser <= res_status;
      if (upd) begin
        m_tdata <= {1'b0, res_all, reo_n, dup_n, recv_n, res_lat, head.slot};
      end else begin
        m_tdata <= {1'b0, res_all, (OUT_TDATA_W - 2)'(0)};
      end
    end
  end

endmodule

// ----- src/multistream_sequence_tracker_core.sv -----
// ----------------------------------------------------------------------------
// multistream_sequence_tracker_core
// per-stream loss, duplicate and reorder tracking of packet headers
// ----------------------------------------------------------------------------
// path: an accepted packet enters the queue; an ignored packet then goes to
//   the result register, a matched one reads its bitmap word, then writes it back as its result is registered
// pacing: a matched packet holds the bitmap port through read and write-back
//   before the next packet is taken; an ignored packet needs no bitmap access
// reset: the bitmap is cleared one 64-bit word a cycle, all 16384 words,
//   during which s_tready stays low
module multistream_sequence_tracker_core import mst_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CNT_W-1:0]       cfg_wr_data,  // expected_stream_count
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // flow_id, sequence_number, planned_total, send_time_ns,
  // arrival_time_ns, packet_length
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // slot_index, latency_ns, received_count, duplicate_count,
  // reorder_count, all_complete, pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [OUT_TUSER_W-1:0] m_tuser       // status
);

  logic [CNT_W-1:0] expected;
  logic   accept, q_empty, q_full, pop, clearing;
  item_t  front_item, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected <= CNT_W'(MAX_SLOTS);
    end else if (cfg_wr_en) begin
      expected <= cfg_wr_data;
    end
  end

  assign s_tready = !clearing && !q_full;
  assign accept   = s_tvalid && s_tready;

  mst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .accept   (accept),
    .expected (expected),
    .item     (front_item)
  );

  mst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  mst_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .expected (expected),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- src/mst_checker.sv -----
// ----------------------------------------------------------------------------
// mst_checker
// port-level checks on the result stream
// ----------------------------------------------------------------------------
module mst_checker import mst_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [OUT_TUSER_W-1:0] m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= OUT_TUSER_W'(ST_REORDER))
    else $error("status code out of range");

  a_ignored: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser < OUT_TUSER_W'(ST_DUP) |-> m_tdata[101:0] == '0)
    else $error("ignored packet carries stream data");

  a_dup_lat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == OUT_TUSER_W'(ST_DUP) |-> m_tdata[35:4] == '0)
    else $error("duplicate reports latency");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[OUT_TDATA_W-1])
    else $error("pad bit set");

endmodule

bind multistream_sequence_tracker_core mst_checker u_mst_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
